>>> rtl/bfo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded FIFO with overflow policy.
// No dependencies.
package bfo_pkg;

  localparam int OP_W        = 3;
  localparam int WORD_W      = 32;
  localparam int CNT_FIELD_W = 11;
  localparam int REG_ADDR_W  = 3;
  localparam int REG_DATA_W  = 32;

  localparam logic [CNT_FIELD_W-1:0] MAX_ENTRIES_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_CLEAR    = 3'd2,
    OP_DROP     = 3'd3,
    OP_SHUTDOWN = 3'd4
  } op_t;

  typedef enum logic {
    REG_MAX_ENTRIES = 1'b0,
    REG_DROP_POLICY = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_READ = 2'd2
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic load;
  } cmd_t;

endpackage

>>> rtl/bfo_regs.sv
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
// Depends on bfo_pkg.
module bfo_regs
  import bfo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [REG_ADDR_W-1:0]  paddr,
  input  logic [REG_DATA_W-1:0]  pwdata,
  output logic [REG_DATA_W-1:0]  prdata,
  output logic                   pready,
  output logic [CNT_FIELD_W-1:0] max_entries,
  output logic                   drop_policy
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
      drop_policy <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_MAX_ENTRIES: max_entries <= pwdata[CNT_FIELD_W-1:0];
        REG_DROP_POLICY: drop_policy <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_ENTRIES: prdata = REG_DATA_W'(max_entries);
      REG_DROP_POLICY: prdata = REG_DATA_W'(drop_policy);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/bfo_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: accept a beat, update the queue, load the result register.
// Depends on bfo_pkg.
module bfo_ctrl
  import bfo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cmd.load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

>>> rtl/bfo_dp.sv
`timescale 1ns / 1ps
// Queue datapath: entry store, pointers, counters and result register.
// Depends on bfo_pkg; driven by bfo_ctrl commands.
module bfo_dp
  import bfo_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [CNT_FIELD_W-1:0] max_entries,
  input  logic                   drop_policy,
  input  logic [OP_W-1:0]        op,
  input  logic [WORD_W-1:0]      payload_in,
  input  logic [CNT_FIELD_W-1:0] drop_count,
  output logic                   ok,
  output logic [WORD_W-1:0]      payload_out,
  output logic [CNT_FIELD_W-1:0] occupancy,
  output logic                   is_empty,
  output logic [CNT_FIELD_W-1:0] peak_occupancy,
  output logic [WORD_W-1:0]      pushed_total,
  output logic [WORD_W-1:0]      popped_total,
  output logic [WORD_W-1:0]      dropped_total
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CNT_FIELD_W) ? CW : CNT_FIELD_W;
  localparam int SW = CW + 1;
  localparam int KW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

  logic [KW-1:0] mem [DEPTH];
  logic [KW-1:0] rd_data;

  logic [OP_W-1:0]        op_q;
  logic [KW-1:0]          payload_q;
  logic [CNT_FIELD_W-1:0] req_q;

  logic [AW-1:0]     head, head_next, tail, tail_next;
  logic [CW-1:0]     count, count_next, peak, peak_next;
  logic              stopped, stopped_next;
  logic [WORD_W-1:0] pushes, pushes_next, pops, pops_next, drops, drops_next;
  logic              ok_res, ok_res_next, pop_res, pop_res_next, wr_en;

  logic [EW-1:0] limit_e;
  logic [CW-1:0] limit, held, n;
  logic          accept;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx, input logic [CW-1:0] k);
    logic [SW-1:0] sum;
    sum = SW'(idx) + SW'(k);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  always_comb begin
    if (max_entries == '0) limit_e = EW'(1);
    else if (EW'(max_entries) > EW'(DEPTH)) limit_e = EW'(DEPTH);
    else limit_e = EW'(max_entries);
    limit = limit_e[CW-1:0];
    if (EW'(req_q) < EW'(count)) n = CW'(req_q);
    else n = count;
  end

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    peak_next    = peak;
    stopped_next = stopped;
    pushes_next  = pushes;
    pops_next    = pops;
    drops_next   = drops;
    ok_res_next  = 1'b0;
    pop_res_next = 1'b0;
    wr_en        = 1'b0;
    accept       = 1'b0;
    held         = count;
    case (op_q)
      OP_PUSH: begin
        if (!stopped) begin
          accept = 1'b1;
          if (count >= limit) begin
            drops_next = drops + 1'b1;
            if (drop_policy && count != '0) begin
              head_next = adv(head, CW'(1));
              held      = count - 1'b1;
            end else begin
              accept = 1'b0;
            end
          end
          if (accept && held < CW'(DEPTH)) begin
            wr_en       = 1'b1;
            tail_next   = adv(tail, CW'(1));
            count_next  = held + 1'b1;
            pushes_next = pushes + 1'b1;
            ok_res_next = 1'b1;
            if (count_next > peak) peak_next = count_next;
          end else begin
            count_next = held;
          end
        end
      end
      OP_POP: begin
        if (!stopped && count != '0) begin
          head_next    = adv(head, CW'(1));
          count_next   = count - 1'b1;
          pops_next    = pops + 1'b1;
          ok_res_next  = 1'b1;
          pop_res_next = 1'b1;
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
      end
      OP_DROP: begin
        head_next  = adv(head, n);
        count_next = count - n;
        drops_next = drops + WORD_W'(n);
      end
      OP_SHUTDOWN: stopped_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[tail] <= payload_q;
    if (cmd.exec) rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q      <= op;
      payload_q <= KW'(payload_in);
      req_q     <= drop_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      peak    <= '0;
      stopped <= 1'b0;
      pushes  <= '0;
      pops    <= '0;
      drops   <= '0;
      ok_res  <= 1'b0;
      pop_res <= 1'b0;
    end else if (cmd.exec) begin
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      peak    <= peak_next;
      stopped <= stopped_next;
      pushes  <= pushes_next;
      pops    <= pops_next;
      drops   <= drops_next;
      ok_res  <= ok_res_next;
      pop_res <= pop_res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok             <= ok_res;
      payload_out    <= pop_res ? WORD_W'(rd_data) : '0;
      occupancy      <= CNT_FIELD_W'(count);
      is_empty       <= (count == '0);
      peak_occupancy <= CNT_FIELD_W'(peak);
      pushed_total   <= pushes;
      popped_total   <= pops;
      dropped_total  <= drops;
    end
  end

endmodule

>>> rtl/bounded_fifo_with_overflow_policy.sv
`timescale 1ns / 1ps
// Top level of the bounded FIFO with overflow policy.
// Depends on bfo_pkg, bfo_regs, bfo_ctrl and bfo_dp.
//
//   channel | handshake            | fields
//   --------+----------------------+-----------------------------------------
//   cfg     | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//   in      | in_valid/in_ready    | op, payload_in, drop_count
//   out     | out_valid/out_ready  | ok, payload_out, occupancy, is_empty,
//           |                      | peak_occupancy, pushed/popped/dropped_total
//
// Each beat passes through accept (ST_IDLE), an update of pointers and
// counters while the entry store is written at the tail and read at the head
// (ST_EXEC), and the load of the result register (ST_READ). The result
// register decouples the sides: the next beat is accepted while a result
// waits, and its own result loads once freed.
// Reset clears pointers, counters and the shutdown flag; the entry store is
// not cleared and needs no clearing pass.
module bounded_fifo_with_overflow_policy
  import bfo_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [REG_ADDR_W-1:0]  paddr,
  input  logic [REG_DATA_W-1:0]  pwdata,
  output logic [REG_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        op,
  input  logic [WORD_W-1:0]      payload_in,
  input  logic [CNT_FIELD_W-1:0] drop_count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   ok,
  output logic [WORD_W-1:0]      payload_out,
  output logic [CNT_FIELD_W-1:0] occupancy,
  output logic                   is_empty,
  output logic [CNT_FIELD_W-1:0] peak_occupancy,
  output logic [WORD_W-1:0]      pushed_total,
  output logic [WORD_W-1:0]      popped_total,
  output logic [WORD_W-1:0]      dropped_total
);

  cmd_t                   cmd;
  logic [CNT_FIELD_W-1:0] max_entries;
  logic                   drop_policy;

  bfo_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_entries (max_entries),
    .drop_policy (drop_policy)
  );

  bfo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bfo_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .max_entries    (max_entries),
    .drop_policy    (drop_policy),
    .op             (op),
    .payload_in     (payload_in),
    .drop_count     (drop_count),
    .ok             (ok),
    .payload_out    (payload_out),
    .occupancy      (occupancy),
    .is_empty       (is_empty),
    .peak_occupancy (peak_occupancy),
    .pushed_total   (pushed_total),
    .popped_total   (popped_total),
    .dropped_total  (dropped_total)
  );

endmodule

>>> dv/bounded_fifo_with_overflow_policy_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_fifo_with_overflow_policy: a scoreboard class predicts each
// result from accepted beats; tasks drive the cfg and input channels, a loop the result channel.
// Depends on bfo_pkg and the RTL under rtl/.
module bounded_fifo_with_overflow_policy_tb;
  import bfo_pkg::*;

  localparam int FIFO_DEPTH = 1024;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic                   ok;
    logic [WORD_W-1:0]      word;
    logic [CNT_FIELD_W-1:0] occ;
    logic                   empty;
    logic [CNT_FIELD_W-1:0] peak;
    logic [WORD_W-1:0]      pushed;
    logic [WORD_W-1:0]      popped;
    logic [WORD_W-1:0]      dropped;
  } fifo_result_t;

  class fifo_scoreboard;
    logic [WORD_W-1:0]      entries [FIFO_DEPTH];
    logic [9:0]             head_ptr;
    logic [9:0]             tail_ptr;
    int                     fill;
    bit                     stopped;
    int                     peak;
    logic [WORD_W-1:0]      pushed;
    logic [WORD_W-1:0]      popped;
    logic [WORD_W-1:0]      dropped;
    logic [CNT_FIELD_W-1:0] limit_reg;
    logic                   drop_policy;
    fifo_result_t           expected_q[$];
    int                     errors;

    function new();
      head_ptr    = '0;
      tail_ptr    = '0;
      fill        = 0;
      stopped     = 0;
      peak        = 0;
      pushed      = '0;
      popped      = '0;
      dropped     = '0;
      limit_reg   = MAX_ENTRIES_RESET;
      drop_policy = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [REG_DATA_W-1:0] val);
      if (idx == REG_MAX_ENTRIES) begin
        limit_reg = val[CNT_FIELD_W-1:0];
      end else begin
        drop_policy = val[0];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_beat(logic [OP_W-1:0] code, logic [WORD_W-1:0] word,
                            logic [CNT_FIELD_W-1:0] req);
      fifo_result_t r;
      int           lim;
      int           n;
      bit           accept;
      r   = '0;
      lim = (limit_reg == 0) ? 1 : (limit_reg > FIFO_DEPTH) ? FIFO_DEPTH : int'(limit_reg);
      case (code)
        OP_PUSH: begin
          if (!stopped) begin
            accept = 1;
            if (fill >= lim) begin
              dropped++;
              if (drop_policy && fill > 0) begin
                head_ptr++;
                fill--;
              end else begin
                accept = 0;
              end
            end
            if (accept && fill < FIFO_DEPTH) begin
              entries[tail_ptr] = word;
              tail_ptr++;
              fill++;
              pushed++;
              if (fill > peak) peak = fill;
              r.ok = 1'b1;
            end
          end
        end
        OP_POP: begin
          if (!stopped && fill > 0) begin
            r.word = entries[head_ptr];
            head_ptr++;
            fill--;
            popped++;
            r.ok = 1'b1;
          end
        end
        OP_CLEAR: begin
          head_ptr = '0;
          tail_ptr = '0;
          fill     = 0;
        end
        OP_DROP: begin
          n        = (int'(req) < fill) ? int'(req) : fill;
          head_ptr = 10'(head_ptr + n);
          fill     = fill - n;
          dropped  = dropped + n;
        end
        OP_SHUTDOWN: begin
          stopped = 1;
        end
        default: begin
        end
      endcase
      r.occ     = CNT_FIELD_W'(fill);
      r.empty   = (fill == 0);
      r.peak    = CNT_FIELD_W'(peak);
      r.pushed  = pushed;
      r.popped  = popped;
      r.dropped = dropped;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t %s: expected %0h, actual %0h", $time, name, want, seen);
      end
    endfunction

    function void check_result(fifo_result_t got);
      fifo_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none, actual %0h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("ok", WORD_W'(want.ok), WORD_W'(got.ok));
      compare_field("payload_out", want.word, got.word);
      compare_field("occupancy", WORD_W'(want.occ), WORD_W'(got.occ));
      compare_field("is_empty", WORD_W'(want.empty), WORD_W'(got.empty));
      compare_field("peak_occupancy", WORD_W'(want.peak), WORD_W'(got.peak));
      compare_field("pushed_total", want.pushed, got.pushed);
      compare_field("popped_total", want.popped, got.popped);
      compare_field("dropped_total", want.dropped, got.dropped);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [REG_ADDR_W-1:0]  paddr;
  logic [REG_DATA_W-1:0]  pwdata;
  logic [REG_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_ready;
  logic [OP_W-1:0]        op;
  logic [WORD_W-1:0]      payload_in;
  logic [CNT_FIELD_W-1:0] drop_count;
  logic                   out_valid;
  logic                   out_ready;
  logic                   ok;
  logic [WORD_W-1:0]      payload_out;
  logic [CNT_FIELD_W-1:0] occupancy;
  logic                   is_empty;
  logic [CNT_FIELD_W-1:0] peak_occupancy;
  logic [WORD_W-1:0]      pushed_total;
  logic [WORD_W-1:0]      popped_total;
  logic [WORD_W-1:0]      dropped_total;

  fifo_scoreboard sb = new();
  bit             send_burst = 1'b0;
  bit             recv_burst = 1'b0;
  int             idle_cycles = 0;

  bounded_fifo_with_overflow_policy #(
    .DEPTH(FIFO_DEPTH),
    .DATA_WIDTH(WORD_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .payload_in(payload_in),
    .drop_count(drop_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ok(ok),
    .payload_out(payload_out),
    .occupancy(occupancy),
    .is_empty(is_empty),
    .peak_occupancy(peak_occupancy),
    .pushed_total(pushed_total),
    .popped_total(popped_total),
    .dropped_total(dropped_total)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_beat(logic [OP_W-1:0] code, logic [WORD_W-1:0] word,
                           logic [CNT_FIELD_W-1:0] req);
    int gap;
    if ($urandom_range(0, 23) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= code;
    payload_in <= word;
    drop_count <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(code, word, req);
  endtask

  // hold the sender until every outstanding result has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic program_regs(logic [CNT_FIELD_W-1:0] limit, logic policy);
    reg_idx_t                idx;
    logic [REG_DATA_W-1:0]   val;
    for (int i = 0; i < 2; i++) begin
      idx     = (i == 0) ? REG_MAX_ENTRIES : REG_DROP_POLICY;
      val     = (i == 0) ? REG_DATA_W'(limit) : REG_DATA_W'(policy);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_reg(idx, val);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(logic [CNT_FIELD_W-1:0] limit, logic policy, int beats,
                           int push_pct, int pop_pct);
    int                     pick;
    logic [OP_W-1:0]        code;
    logic [CNT_FIELD_W-1:0] req;
    drain_results();
    program_regs(limit, policy);
    for (int i = 0; i < beats; i++) begin
      pick = $urandom_range(0, 99);
      req  = ($urandom_range(0, 3) == 0) ? CNT_FIELD_W'($urandom_range(0, 2047))
                                         : CNT_FIELD_W'($urandom_range(0, 4));
      if (pick < push_pct) begin
        code = OP_PUSH;
      end else if (pick < push_pct + pop_pct) begin
        code = OP_POP;
      end else if (pick < push_pct + pop_pct + 2) begin
        code = OP_CLEAR;
      end else if (pick >= 97) begin
        code = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
      end else begin
        code = OP_DROP;
      end
      send_beat(code, $urandom(), req);
      if ($urandom_range(0, 63) == 0) drain_results();
    end
  endtask

  initial begin
    fifo_result_t got;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int stall;
      if ($urandom_range(0, 23) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{ok, payload_out, occupancy, is_empty, peak_occupancy,
              pushed_total, popped_total, dropped_total};
      sb.check_result(got);
    end
  end

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    op          = OP_PUSH;
    payload_in  = '0;
    drop_count  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_beat(OP_POP, 32'h0, 11'd0);
    send_beat(OP_PUSH, 32'h0000_0000, 11'd0);
    send_beat(OP_PUSH, 32'hFFFF_FFFF, 11'd2047);
    send_beat(OP_PUSH, 32'h5A5A_A5A5, 11'd0);
    send_beat(OP_POP, 32'hFFFF_FFFF, 11'd0);
    send_beat(OP_POP, 32'h0, 11'd0);
    send_beat(OP_DROP, 32'h0, 11'd0);
    send_beat(OP_DROP, 32'h0, 11'd1);
    send_beat(OP_PUSH, 32'h1234_5678, 11'd0);
    send_beat(OP_PUSH, 32'h8765_4321, 11'd0);
    send_beat(OP_PUSH, 32'hDEAD_BEEF, 11'd0);
    send_beat(OP_DROP, 32'h0, 11'd2047);
    send_beat(OP_PUSH, 32'hCAFE_F00D, 11'd0);
    send_beat(OP_PUSH, 32'h0F0F_0F0F, 11'd0);
    send_beat(OP_CLEAR, 32'h0, 11'd0);
    send_beat(OP_POP, 32'h0, 11'd0);
    send_beat(OP_PUSH, 32'h8000_0001, 11'd0);
    send_beat(OP_RSVD5, 32'hFFFF_FFFF, 11'd1024);
    send_beat(OP_RSVD5 + 3'd1, 32'h0, 11'd0);
    send_beat(OP_RSVD7, 32'h0, 11'd2047);
    send_beat(OP_DROP, 32'h0, 11'd1024);
    send_beat(OP_POP, 32'h0, 11'd0);

    run_phase(11'd0, 1'b1, 40, 50, 35);
    run_phase(11'd1, 1'b0, 40, 50, 35);
    run_phase(11'd8, 1'b0, 60, 55, 30);
    run_phase(11'd8, 1'b1, 60, 55, 30);
    run_phase(11'd64, 1'b1, 80, 70, 20);
    run_phase(11'd5, 1'b0, 50, 40, 30);
    run_phase(11'd5, 1'b1, 50, 45, 30);
    run_phase(11'd2047, 1'b0, 80, 55, 30);
    run_phase(11'd1024, 1'b0, 120, 97, 3);
    run_phase(11'd1024, 1'b1, 50, 70, 10);
    run_phase(11'd3, 1'b1, 40, 40, 40);

    // shutdown is sticky: exercise it last, with entries still held
    send_beat(OP_PUSH, 32'hA5A5_5A5A, 11'd0);
    send_beat(OP_PUSH, 32'h3C3C_C3C3, 11'd0);
    send_beat(OP_SHUTDOWN, 32'h0, 11'd0);
    send_beat(OP_PUSH, 32'hFFFF_FFFF, 11'd0);
    send_beat(OP_POP, 32'h0, 11'd0);
    send_beat(OP_DROP, 32'h0, 11'd1);
    send_beat(OP_SHUTDOWN, 32'h0, 11'd0);
    send_beat(OP_POP, 32'h0, 11'd0);
    send_beat(OP_CLEAR, 32'h0, 11'd0);
    send_beat(OP_PUSH, 32'h0, 11'd0);
    send_beat(OP_RSVD7, 32'h0, 11'd0);

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bfo_pkg.sv
rtl/bfo_regs.sv
rtl/bfo_ctrl.sv
rtl/bfo_dp.sv
rtl/bounded_fifo_with_overflow_policy.sv
dv/bounded_fifo_with_overflow_policy_tb.sv
